[design/lorenz_euler_stepper_defines.svh]
// ---------------------------------------------------------------------------
// Lorenz Euler stepper assertion macros
// Shared concurrent assertion forms for the stepper's checks.
// ---------------------------------------------------------------------------
`ifndef LORENZ_EULER_STEPPER_DEFINES_SVH
`define LORENZ_EULER_STEPPER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LES_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LES_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[design/les_pkg.sv]
// ---------------------------------------------------------------------------
// Lorenz Euler stepper package
// Shared types for the controller/datapath command interface and coefficients.
// ---------------------------------------------------------------------------
package les_pkg;

   localparam int unsigned DATA_W = 32;
   localparam int unsigned DT_W   = 31;

   // Coefficient register index, byte address is 4 times the index
   typedef enum logic [1:0] {
      REG_SIGMA,
      REG_RHO,
      REG_BETA,
      REG_DT
   } csr_reg_type;

   // Operand pair loaded into the shared multiplier
   typedef enum logic [2:0] {
      MUL_XY,   // x * y
      MUL_BZ,   // beta * z
      MUL_SD,   // sigma * (y - x)
      MUL_XD,   // x * (rho - z)
      MUL_TZ,   // dt * dz
      MUL_TX,   // dt * dx
      MUL_TY    // dt * dy
   } mul_sel_type;

   // Destination of the rounded product
   typedef enum logic [2:0] {
      WB_NONE,
      WB_T1,    // hold x*y
      WB_DZ,    // dz = x*y - beta*z
      WB_DX,    // dx = sigma*(y-x)
      WB_DY,    // dy = x*(rho-z) - y
      WB_Z,     // z += dt*dz
      WB_X,     // x += dt*dx
      WB_Y      // y += dt*dy
   } wb_sel_type;

   typedef struct packed {
      logic        start;     // request accepted: restart point, clear flag
      logic        diff;      // form y-x and rho-z
      logic        issue;     // load multiplier operands
      mul_sel_type mul_sel;
      wb_sel_type  wb_sel;
      logic        load_out;  // move point into the response register
   } dp_cmd_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] sigma;
      logic signed [DATA_W-1:0] rho;
      logic signed [DATA_W-1:0] beta;
      logic        [DT_W-1:0]   dt;
   } coef_type;

endpackage

[design/les_ctrl.sv]
// ---------------------------------------------------------------------------
// Lorenz Euler stepper controller
// Sequences one Euler step through the shared multiplier and owns handshakes.
// ---------------------------------------------------------------------------
module les_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output les_pkg::dp_cmd_type cmd
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_XY,
      ST_BZ,
      ST_SD,
      ST_XD,
      ST_TZ,
      ST_TX,
      ST_TY,
      ST_WX,
      ST_WY,
      ST_OUT
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Command decode: each product is issued into the operand registers and written back from the product register
   always_comb begin
      cmd          = '0;
      cmd.mul_sel  = les_pkg::MUL_XY;
      cmd.wb_sel   = les_pkg::WB_NONE;
      unique case (state_ff)
         ST_IDLE: cmd.start = req_valid;
         ST_XY: begin
            cmd.diff    = 1'b1;
            cmd.issue   = 1'b1;
            cmd.mul_sel = les_pkg::MUL_XY;
         end
         ST_BZ: begin
            cmd.issue   = 1'b1;
            cmd.mul_sel = les_pkg::MUL_BZ;
         end
         ST_SD: begin
            cmd.issue   = 1'b1;
            cmd.mul_sel = les_pkg::MUL_SD;
            cmd.wb_sel  = les_pkg::WB_T1;
         end
         ST_XD: begin
            cmd.issue   = 1'b1;
            cmd.mul_sel = les_pkg::MUL_XD;
            cmd.wb_sel  = les_pkg::WB_DZ;
         end
         ST_TZ: begin
            cmd.issue   = 1'b1;
            cmd.mul_sel = les_pkg::MUL_TZ;
            cmd.wb_sel  = les_pkg::WB_DX;
         end
         ST_TX: begin
            cmd.issue   = 1'b1;
            cmd.mul_sel = les_pkg::MUL_TX;
            cmd.wb_sel  = les_pkg::WB_DY;
         end
         ST_TY: begin
            cmd.issue   = 1'b1;
            cmd.mul_sel = les_pkg::MUL_TY;
            cmd.wb_sel  = les_pkg::WB_Z;
         end
         ST_WX:  cmd.wb_sel   = les_pkg::WB_X;
         ST_WY:  cmd.wb_sel   = les_pkg::WB_Y;
         ST_OUT: cmd.load_out = out_free;
         default: cmd = '0;
      endcase
   end

   // State and response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         // set as a step completes, cleared once the response is taken
         if ((state_ff == ST_OUT) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: if (req_valid) state_ff <= ST_XY;
            ST_XY:   state_ff <= ST_BZ;
            ST_BZ:   state_ff <= ST_SD;
            ST_SD:   state_ff <= ST_XD;
            ST_XD:   state_ff <= ST_TZ;
            ST_TZ:   state_ff <= ST_TX;
            ST_TX:   state_ff <= ST_TY;
            ST_TY:   state_ff <= ST_WX;
            ST_WX:   state_ff <= ST_WY;
            ST_WY:   state_ff <= ST_OUT;
            ST_OUT: begin
               if (out_free) state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

[design/les_dpath.sv]
// ---------------------------------------------------------------------------
// Lorenz Euler stepper datapath
// Point registers, shared rounding multiplier and saturating adder.
// ---------------------------------------------------------------------------
module les_dpath #(
   parameter int unsigned FRAC_BITS = 24
) (
   input  logic                     clock,
   input  logic                     reset,
   input  les_pkg::dp_cmd_type      cmd,
   input  les_pkg::coef_type        coef,
   input  logic                     req_restart,
   output logic signed [31:0]       rsp_point_x,
   output logic signed [31:0]       rsp_point_y,
   output logic signed [31:0]       rsp_point_z,
   output logic                     rsp_saturated
);

   localparam logic signed [31:0] ONE      = 32'sd1 <<< FRAC_BITS;
   localparam logic signed [63:0] RND_HALF = 64'sd1 <<< (FRAC_BITS - 1);
   localparam logic signed [31:0] MAX32    = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] MIN32    = 32'sh8000_0000;

   typedef struct packed {
      logic              sat;
      logic signed [31:0] val;
   } sat_res_type;

   function automatic sat_res_type clamp33(input logic signed [32:0] v);
      sat_res_type r;
      r.sat = (v[32] != v[31]);
      r.val = r.sat ? (v[32] ? MIN32 : MAX32) : v[31:0];
      return r;
   endfunction

   logic signed [31:0] x_ff, y_ff, z_ff;
   logic signed [31:0] dyx_ff, drz_ff;
   logic signed [31:0] t1_ff, dx_ff, dy_ff, dz_ff;
   logic signed [31:0] op_a_ff, op_b_ff, op_a_in, op_b_in;
   logic signed [63:0] prod_ff, prod_in;
   logic signed [63:0] prod_rnd, prod_sh;
   logic signed [31:0] fm;
   logic               fm_sat;
   logic signed [31:0] sum_a, sum_b;
   logic               sum_sub;
   logic signed [32:0] sum_wide;
   sat_res_type        sum_res, dyx_res, drz_res;
   logic               sat_ff;
   logic signed [31:0] out_x_ff, out_y_ff, out_z_ff;
   logic               out_sat_ff;
   logic signed [31:0] dt_s;

   assign dt_s = {1'b0, coef.dt};

   // Differences feeding the sigma and rho products
   assign dyx_res = clamp33({y_ff[31], y_ff} - {x_ff[31], x_ff});
   assign drz_res = clamp33({coef.rho[31], coef.rho} - {z_ff[31], z_ff});

   // Multiplier operand select
   always_comb begin
      op_a_in = x_ff;
      op_b_in = y_ff;
      unique case (cmd.mul_sel)
         les_pkg::MUL_XY: begin op_a_in = x_ff;      op_b_in = y_ff;   end
         les_pkg::MUL_BZ: begin op_a_in = coef.beta; op_b_in = z_ff;   end
         les_pkg::MUL_SD: begin op_a_in = coef.sigma; op_b_in = dyx_ff; end
         les_pkg::MUL_XD: begin op_a_in = x_ff;      op_b_in = drz_ff; end
         les_pkg::MUL_TZ: begin op_a_in = dt_s;      op_b_in = dz_ff;  end
         les_pkg::MUL_TX: begin op_a_in = dt_s;      op_b_in = dx_ff;  end
         les_pkg::MUL_TY: begin op_a_in = dt_s;      op_b_in = dy_ff;  end
         default: begin op_a_in = x_ff; op_b_in = y_ff; end
      endcase
   end

   // 32x32 signed product, registered
   assign prod_in = op_a_ff * op_b_ff;

   // Round half up, drop fraction bits, saturate to 32 bits
   assign prod_rnd = prod_ff + RND_HALF;
   assign prod_sh  = prod_rnd >>> FRAC_BITS;
   assign fm_sat   = !((&prod_sh[63:31]) || !(|prod_sh[63:31]));
   assign fm       = fm_sat ? (prod_sh[63] ? MIN32 : MAX32) : prod_sh[31:0];

   // Shared saturating add/subtract for write back
   always_comb begin
      sum_a   = fm;
      sum_b   = '0;
      sum_sub = 1'b0;
      unique case (cmd.wb_sel)
         les_pkg::WB_DZ: begin sum_a = t1_ff; sum_b = fm;   sum_sub = 1'b1; end
         les_pkg::WB_DY: begin sum_a = fm;    sum_b = y_ff; sum_sub = 1'b1; end
         les_pkg::WB_Z:  begin sum_a = z_ff;  sum_b = fm; end
         les_pkg::WB_X:  begin sum_a = x_ff;  sum_b = fm; end
         les_pkg::WB_Y:  begin sum_a = y_ff;  sum_b = fm; end
         default: begin sum_a = fm; sum_b = '0; end
      endcase
      sum_wide = sum_sub ? ({sum_a[31], sum_a} - {sum_b[31], sum_b})
                         : ({sum_a[31], sum_a} + {sum_b[31], sum_b});
   end

   assign sum_res = clamp33(sum_wide);

   // Point state and saturation flag
   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff   <= ONE;
         y_ff   <= ONE;
         z_ff   <= ONE;
         sat_ff <= 1'b0;
      end else begin
         if (cmd.start) begin
            sat_ff <= 1'b0;
            if (req_restart) begin
               x_ff <= ONE;
               y_ff <= ONE;
               z_ff <= ONE;
            end
         end
         if (cmd.diff && (dyx_res.sat || drz_res.sat)) begin
            sat_ff <= 1'b1;
         end
         unique case (cmd.wb_sel)
            les_pkg::WB_NONE: ;
            les_pkg::WB_T1, les_pkg::WB_DX: begin
               if (fm_sat) sat_ff <= 1'b1;
            end
            default: begin
               if (fm_sat || sum_res.sat) sat_ff <= 1'b1;
            end
         endcase
         if (cmd.wb_sel == les_pkg::WB_Z) z_ff <= sum_res.val;
         if (cmd.wb_sel == les_pkg::WB_X) x_ff <= sum_res.val;
         if (cmd.wb_sel == les_pkg::WB_Y) y_ff <= sum_res.val;
      end
   end

   // Intermediate terms and multiplier pipeline
   always_ff @(posedge clock) begin
      if (cmd.diff) begin
         dyx_ff <= dyx_res.val;
         drz_ff <= drz_res.val;
      end
      if (cmd.issue) begin
         op_a_ff <= op_a_in;
         op_b_ff <= op_b_in;
      end
      prod_ff <= prod_in;
      if (cmd.wb_sel == les_pkg::WB_T1) t1_ff <= fm;
      if (cmd.wb_sel == les_pkg::WB_DX) dx_ff <= fm;
      if (cmd.wb_sel == les_pkg::WB_DY) dy_ff <= sum_res.val;
      if (cmd.wb_sel == les_pkg::WB_DZ) dz_ff <= sum_res.val;
   end

   // Response payload register
   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_x_ff   <= x_ff;
         out_y_ff   <= y_ff;
         out_z_ff   <= z_ff;
         out_sat_ff <= sat_ff;
      end
   end

   assign rsp_point_x   = out_x_ff;
   assign rsp_point_y   = out_y_ff;
   assign rsp_point_z   = out_z_ff;
   assign rsp_saturated = out_sat_ff;

endmodule

[design/lorenz_euler_stepper.sv]
// ---------------------------------------------------------------------------
// Lorenz Euler stepper
// Forward Euler integrator of the Lorenz system in signed fixed point.
// ---------------------------------------------------------------------------
// Usage:
//   Each request on the req_ channel advances the point (x, y, z) by one
//   Euler step; req_restart reloads (1,1,1) before that step. Each request
//   yields exactly one response on the rsp_ channel carrying the new point
//   and a flag set when any difference, product or sum was clamped.
//   Coefficients sigma, rho, beta and dt sit in an APB register file at
//   byte addresses 0, 4, 8 and 12; write them only while no step is pending.
// Timing:
//   One shared 32x32 multiplier with a two-stage pipeline serves all seven
//   products of a step. A request is taken only in idle; further requests
//   are stalled until the step has moved into the response register, and
//   the response becomes valid as it does.
//   The response register lets a finished point wait while the next step
//   runs; a step completes into it only once it is free.
// Reset:
//   Synchronous reset clears the handshake state, sets the point to
//   (1,1,1) and loads the default coefficients scaled to FRAC_BITS.
// ---------------------------------------------------------------------------
`include "lorenz_euler_stepper_defines.svh"

module lorenz_euler_stepper #(
   parameter int unsigned FRAC_BITS = 24
) (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_restart,
   // response channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_point_x,
   output logic signed [31:0] rsp_point_y,
   output logic signed [31:0] rsp_point_z,
   output logic               rsp_saturated,
   // register port
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [3:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   // Default coefficients, rescaled from Q8.24 and clamped
   localparam logic [63:0] SIGMA_SC = (64'd167772160 << FRAC_BITS) >> 24;
   localparam logic [63:0] RHO_SC   = (64'd469762048 << FRAC_BITS) >> 24;
   localparam logic [63:0] BETA_SC  = (64'd44738226 << FRAC_BITS) >> 24;
   localparam logic [63:0] DT_SC    = (64'd16777 << FRAC_BITS) >> 24;
   localparam logic [63:0] LIMIT    = 64'h0000_0000_7FFF_FFFF;
   localparam logic [31:0] SIGMA_RST = (SIGMA_SC > LIMIT) ? LIMIT[31:0] : SIGMA_SC[31:0];
   localparam logic [31:0] RHO_RST   = (RHO_SC > LIMIT) ? LIMIT[31:0] : RHO_SC[31:0];
   localparam logic [31:0] BETA_RST  = (BETA_SC > LIMIT) ? LIMIT[31:0] : BETA_SC[31:0];
   localparam logic [30:0] DT_RST    = (DT_SC > LIMIT) ? LIMIT[30:0] : DT_SC[30:0];

   les_pkg::coef_type    coef_ff;
   les_pkg::dp_cmd_type  cmd;
   logic                 csr_wr;
   les_pkg::csr_reg_type csr_sel;

   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite;
   assign csr_sel = les_pkg::csr_reg_type'(paddr[3:2]);

   // Coefficient registers
   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff.sigma <= SIGMA_RST;
         coef_ff.rho   <= RHO_RST;
         coef_ff.beta  <= BETA_RST;
         coef_ff.dt    <= DT_RST;
      end else if (csr_wr) begin
         unique case (csr_sel)
            les_pkg::REG_SIGMA: coef_ff.sigma <= pwdata;
            les_pkg::REG_RHO:   coef_ff.rho   <= pwdata;
            les_pkg::REG_BETA:  coef_ff.beta  <= pwdata;
            les_pkg::REG_DT:    coef_ff.dt    <= pwdata[30:0];
            default:            ;
         endcase
      end
   end

   // Register readback
   always_comb begin
      unique case (csr_sel)
         les_pkg::REG_SIGMA: prdata = coef_ff.sigma;
         les_pkg::REG_RHO:   prdata = coef_ff.rho;
         les_pkg::REG_BETA:  prdata = coef_ff.beta;
         les_pkg::REG_DT:    prdata = {1'b0, coef_ff.dt};
         default:            prdata = '0;
      endcase
   end

   les_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   les_dpath #(
      .FRAC_BITS (FRAC_BITS)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .coef          (coef_ff),
      .req_restart   (req_restart),
      .rsp_point_x   (rsp_point_x),
      .rsp_point_y   (rsp_point_y),
      .rsp_point_z   (rsp_point_z),
      .rsp_saturated (rsp_saturated)
   );

   // Checks
   `LES_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && !req_stall, req_stall, "request accepted but stepper not busy")
   `LES_ASSERT_NOW(a_rsp_ends_step, clock, reset, $rose(rsp_valid), !req_stall, "response raised while a step is still running")
   `LES_ASSERT_NEXT(a_sigma_write, clock, reset, csr_wr && (csr_sel == les_pkg::REG_SIGMA), coef_ff.sigma == $past(pwdata), "sigma register write lost")

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Lorenz Euler stepper testbench
// Drives step requests and coefficient writes into the stepper. A local
// fixed-point model of the Euler step predicts every response point and
// saturation flag. Each response is checked against the oldest prediction
// while both channels idle and stall at random.
// ---------------------------------------------------------------------------
module testbench;

   localparam int FRAC = 24;
   localparam logic signed [31:0] UNIT = 32'sd1 <<< FRAC;

   typedef struct {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
      logic               sat;
   } lorenz_point_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic               req_restart;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [31:0] rsp_point_x;
   logic signed [31:0] rsp_point_y;
   logic signed [31:0] rsp_point_z;
   logic               rsp_saturated;
   logic               psel;
   logic               penable;
   logic               pwrite;
   logic [3:0]         paddr;
   logic [31:0]        pwdata;
   logic [31:0]        prdata;
   logic               pready;

   // model state: coefficients and current point
   logic signed [31:0] sigma_q;
   logic signed [31:0] rho_q;
   logic signed [31:0] beta_q;
   logic [30:0]        dt_q;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic signed [31:0] pos_z;
   bit                 step_clamped;

   lorenz_point_type pending_points[$];
   int               errors = 0;
   int               send_idle_pct = 0;
   int               recv_stall_pct = 0;

   lorenz_euler_stepper #(
      .FRAC_BITS(FRAC)
   ) dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_restart  (req_restart),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_point_x  (rsp_point_x),
      .rsp_point_y  (rsp_point_y),
      .rsp_point_z  (rsp_point_z),
      .rsp_saturated(rsp_saturated),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .prdata       (prdata),
      .pready       (pready)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // hard stop in case the block hangs
   initial begin
      #4000000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Fixed-point step model
   // ------------------------------------------------------------------------

   // saturate to 32-bit signed, note any clamp
   function automatic logic signed [31:0] clamp_word(input longint v);
      if (v > 64'sd2147483647) begin
         step_clamped = 1'b1;
         return 32'sh7FFFFFFF;
      end
      if (v < -64'sd2147483648) begin
         step_clamped = 1'b1;
         return 32'sh80000000;
      end
      return v[31:0];
   endfunction

   // product rounded to nearest, ties up, then saturated
   function automatic logic signed [31:0] qmul(input longint a, input longint b);
      longint prod;
      prod = a * b + (64'sd1 <<< (FRAC - 1));
      return clamp_word(prod >>> FRAC);
   endfunction

   // Q8.24 reset value rescaled to FRAC, capped at the positive limit
   function automatic logic [31:0] scaled_default(input longint q24);
      longint v;
      v = (q24 <<< FRAC) >>> 24;
      return (v > 64'sd2147483647) ? 32'h7FFFFFFF : v[31:0];
   endfunction

   // one Euler step of the point, returns the expected response
   function automatic lorenz_point_type advance_point(input logic restart);
      longint             x, y, z, dt;
      logic signed [31:0] dx, dy, dz, t1, t2;
      lorenz_point_type   pt;
      step_clamped = 1'b0;
      if (restart) begin
         pos_x = UNIT;
         pos_y = UNIT;
         pos_z = UNIT;
      end
      x  = pos_x;
      y  = pos_y;
      z  = pos_z;
      dt = longint'(dt_q);
      dx = qmul(sigma_q, clamp_word(y - x));
      t1 = qmul(x, clamp_word(longint'(rho_q) - z));
      dy = clamp_word(longint'(t1) - y);
      t1 = qmul(x, y);
      t2 = qmul(beta_q, z);
      dz = clamp_word(longint'(t1) - longint'(t2));
      pos_x = clamp_word(x + longint'(qmul(dt, dx)));
      pos_y = clamp_word(y + longint'(qmul(dt, dy)));
      pos_z = clamp_word(z + longint'(qmul(dt, dz)));
      pt.x   = pos_x;
      pt.y   = pos_y;
      pt.z   = pos_z;
      pt.sat = step_clamped;
      return pt;
   endfunction

   // ------------------------------------------------------------------------
   // Drivers
   // ------------------------------------------------------------------------

   task automatic report_mismatch(input string what, input logic [31:0] want,
                                  input logic [31:0] got);
      errors++;
      if (errors <= 10)
         $display("%0t: %s mismatch: expected %h, got %h", $realtime, what, want, got);
   endtask

   // response stall, redrawn every cycle
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
   end

   // response checker
   always @(posedge clock) begin : check_response
      lorenz_point_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_points.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("%0t: response with no request pending: %h %h %h %b", $realtime,
                        rsp_point_x, rsp_point_y, rsp_point_z, rsp_saturated);
         end else begin
            want = pending_points.pop_front();
            if (rsp_point_x !== want.x) report_mismatch("point_x", want.x, rsp_point_x);
            if (rsp_point_y !== want.y) report_mismatch("point_y", want.y, rsp_point_y);
            if (rsp_point_z !== want.z) report_mismatch("point_z", want.z, rsp_point_z);
            if (rsp_saturated !== want.sat)
               report_mismatch("saturated", 32'(want.sat), 32'(rsp_saturated));
         end
      end
   end

   // send one step request; entered and left at a falling edge
   task automatic send_request(input logic restart);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_restart <= restart;
      do @(posedge clock); while (req_stall);
      pending_points.push_back(advance_point(restart));
      @(negedge clock);
   endtask

   // stop sending and let every pending step come out
   task automatic drain_steps();
      req_valid <= 1'b0;
      while (pending_points.size() != 0) @(negedge clock);
      repeat (12) @(negedge clock);
   endtask

   // register write followed by a read-back
   task automatic write_coef(input les_pkg::csr_reg_type idx, input logic [31:0] value);
      logic [31:0] readback;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      unique case (idx)
         les_pkg::REG_SIGMA: sigma_q = value;
         les_pkg::REG_RHO:   rho_q   = value;
         les_pkg::REG_BETA:  beta_q  = value;
         les_pkg::REG_DT:    dt_q    = value[30:0];
      endcase
      readback = (idx == les_pkg::REG_DT) ? {1'b0, value[30:0]} : value;
      @(negedge clock);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== readback) report_mismatch("register read-back", readback, prdata);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic set_coefs(input logic [31:0] sigma, input logic [31:0] rho,
                            input logic [31:0] beta, input logic [31:0] dt);
      drain_steps();
      write_coef(les_pkg::REG_SIGMA, sigma);
      write_coef(les_pkg::REG_RHO, rho);
      write_coef(les_pkg::REG_BETA, beta);
      write_coef(les_pkg::REG_DT, dt);
   endtask

   // stream of steps; idling mode rotates every 40 requests
   task automatic run_steps(input int count, input int restart_pct);
      for (int i = 0; i < count; i++) begin
         if (i % 40 == 0) begin
            unique case ((i / 40) % 4)
               0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
               1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
               2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
               default: begin send_idle_pct = 9; recv_stall_pct = 9; end
            endcase
         end
         send_request($urandom_range(0, 99) < restart_pct);
      end
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // first steps from the reset point with reset coefficients, then a restart
   task automatic test_reset_point();
      send_request(1'b0);
      send_request(1'b0);
      send_request(1'b1);
      send_request(1'b0);
   endtask

   // coefficients at both limits, zero and full time step, saturation paths
   task automatic test_coef_extremes();
      set_coefs(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF);
      send_request(1'b1);
      repeat (4) send_request(1'b0);
      send_request(1'b1);
      // time step bit 31 is not part of the register
      set_coefs(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF);
      send_request(1'b1);
      repeat (4) send_request(1'b0);
      // zero time step: point stays put
      set_coefs(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h00000000);
      send_request(1'b0);
      send_request(1'b1);
      send_request(1'b0);
   endtask

   // long runs on the attractor with reset coefficients and a few time steps
   task automatic test_chaotic_orbit();
      for (int seg = 0; seg < 3; seg++) begin
         set_coefs(scaled_default(167772160), scaled_default(469762048),
                   scaled_default(44738226),
                   (seg == 0) ? scaled_default(16777) : $urandom_range(16777, 335544));
         send_request(1'b1);
         run_steps(199, 1);
      end
   endtask

   // coefficients drawn from a physically sensible range
   task automatic test_random_coefs();
      for (int ph = 0; ph < 10; ph++) begin
         set_coefs($urandom_range(0, 20 << 24), $urandom_range(0, 50 << 24),
                   $urandom_range(0, 8 << 24), $urandom_range(0, 838860));
         run_steps(70, 5);
      end
   endtask

   // any register value: heavy saturation, negative coefficients, huge steps
   task automatic test_full_range_coefs();
      for (int ph = 0; ph < 8; ph++) begin
         set_coefs($urandom(), $urandom(), $urandom(), $urandom());
         run_steps(50, 20);
      end
   endtask

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_restart = 1'b0;
      psel        = 1'b0;
      penable     = 1'b0;
      pwrite      = 1'b0;
      paddr       = '0;
      pwdata      = '0;
      sigma_q     = scaled_default(167772160);
      rho_q       = scaled_default(469762048);
      beta_q      = scaled_default(44738226);
      dt_q        = 31'(scaled_default(16777));
      pos_x       = UNIT;
      pos_y       = UNIT;
      pos_z       = UNIT;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_reset_point();
      test_coef_extremes();
      test_chaotic_orbit();
      test_random_coefs();
      test_full_range_coefs();
      drain_steps();

      if (errors == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

[filelist.f]
+incdir+design
design/les_pkg.sv
design/les_ctrl.sv
design/les_dpath.sv
design/lorenz_euler_stepper.sv
dv/testbench.sv
